### sv/ibwe_pkg.sv
`default_nettype none
package ibwe_pkg;

    localparam int NUM_CH = 6;
    localparam int CH_W = 3;
    localparam logic [CH_W-1:0] CH_ACCEL_Z = 3'd5;
    localparam logic [CH_W-1:0] CH_FIRST_ACCEL = 3'd3;

    localparam int REG_W = 24;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_STD_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_STD_LIMIT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_NORM_TOLERANCE = 2'd3;

    localparam logic [REG_W-1:0] GRAVITY_RESET = 24'd642690;
    localparam logic [REG_W-1:0] GYRO_STD_LIMIT_RESET = 24'd655;
    localparam logic [REG_W-1:0] ACCEL_STD_LIMIT_RESET = 24'd3277;
    localparam logic [REG_W-1:0] NORM_TOLERANCE_RESET = 24'd13107;

    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;

    localparam int BIAS_W = 24;
    localparam int STD_W = 24;
    localparam int COUNT_OUT_W = 16;

    localparam int DIV_W = 64;
    localparam int ROOT_W = 32;
    localparam int MUL_W = 32;
    localparam int SUM_W = 64;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_U_RD,
        ST_U_DIFF,
        ST_U_DIV,
        ST_U_MUL,
        ST_U_WB,
        ST_R_RD,
        ST_R_MEAN,
        ST_R_VAR,
        ST_R_STD,
        ST_R_SQ,
        ST_R_SEDIV,
        ST_R_SESQRT,
        ST_R_NEXT,
        ST_N_MUL,
        ST_N_START,
        ST_N_SQRT,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

### sv/ibwe_div.sv
`default_nettype none
module ibwe_div
    import ibwe_pkg::*;
#(
    parameter int VW = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [VW-1:0]    divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= VW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[VW-1:0];
            end
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### sv/ibwe_isqrt.sv
`default_nettype none
module ibwe_isqrt
    import ibwe_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [2*ROOT_W-1:0] radicand,
    output logic                     done,
    output logic [ROOT_W-1:0]        root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] src_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ROOT_W+3:0]   partial;
    logic [ROOT_W+3:0]   trial;
    logic                fits;

    assign partial = {rem_reg, src_reg[2*ROOT_W-1:2*ROOT_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits = partial >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            src_reg <= {src_reg[2*ROOT_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg <= (ROOT_W+2)'(partial - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

### sv/imu_bias_welford_estimator_unit.sv
// Running mean and variance of six IMU channels, with a stationary test.
// Input channel: one transfer per request (add a sample, clear, or report only).
// in_stall stays high from the accepted transfer until the sixth result has been
// placed in the output register; the next request may then be taken while that
// result still waits on the output channel.
// Output channel: six result transfers per request, channel 0 to 5, last on 5.
// A held result stays on the ports while out_stall is high.
// The run time of a request is set by the shared 64-step divider (one quotient bit per
// cycle) and the shared 32-step square root, and by the passes over the channels through
// the statistics memories. With two or more samples counted at report time, an add uses
// the divider three times and the square root twice per channel, a report-only request
// each twice per channel; with fewer, only an add uses the divider, once per channel.
// The configuration port writes the register named by cfg_index; it is to be written
// only while the block is idle, which the block itself does not enforce.
// Reset clears the sample count and the control state and loads the register
// defaults. The statistics memories are not swept: while the count is zero
// their contents read as zero, and every add below the count's maximum writes all six entries.
`default_nettype none
module imu_bias_welford_estimator_unit
    import ibwe_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [REQ_W-1:0]              req_type,
    input  wire logic signed [SAMPLE_BITS-1:0] gyro_x,
    input  wire logic signed [SAMPLE_BITS-1:0] gyro_y,
    input  wire logic signed [SAMPLE_BITS-1:0] gyro_z,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [CH_W-1:0]                    channel,
    output logic signed [BIAS_W-1:0]           bias,
    output logic [STD_W-1:0]                   std_dev,
    output logic [STD_W-1:0]                   std_error,
    output logic [COUNT_OUT_W-1:0]             sample_count,
    output logic                               stats_valid,
    output logic                               stationary,
    output logic                               last,
    input  wire logic                          cfg_write,
    input  wire logic [REG_IDX_W-1:0]          cfg_index,
    input  wire logic [REG_W-1:0]              cfg_data
);

    localparam int MW = SAMPLE_BITS + FRAC_BITS;
    localparam int DW = MW + 1;
    localparam int H = (DW + 1) / 2;
    localparam int PW = 2 * DW;

    state_t state_reg;
    state_t state_next;

    logic [REG_W-1:0] gravity_reg;
    logic [REG_W-1:0] gyro_lim_reg;
    logic [REG_W-1:0] accel_lim_reg;
    logic [REG_W-1:0] norm_tol_reg;

    logic [COUNT_BITS-1:0] count_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [2:0]            step_reg;
    logic                  std_ok_reg;
    logic                  norm_ok_reg;

    logic signed [SAMPLE_BITS-1:0] samp_reg [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] meanr_reg [NUM_CH];
    logic [ROOT_W-1:0]             std_reg [NUM_CH];
    logic [ROOT_W-1:0]             se_reg [NUM_CH];

    logic signed [MW-1:0] mean_mem [NUM_CH];
    logic [SUM_W-1:0]     sq_mem [NUM_CH];
    logic signed [MW-1:0] rd_mean_reg;
    logic [SUM_W-1:0]     rd_sq_reg;
    logic                 mem_we;

    logic signed [MW-1:0] mean_reg;
    logic signed [MW-1:0] newmean_reg;
    logic [SUM_W-1:0]     sq_reg;
    logic signed [DW-1:0] d_reg;
    logic [DW-1:0]        a_reg;
    logic [DW-1:0]        b_reg;
    logic [PW-1:0]        acc_reg;
    logic [2*MUL_W-1:0]   prod_reg;
    logic [SUM_W-1:0]     nsq_reg;

    logic                       out_valid_reg;
    logic [CH_W-1:0]            channel_reg;
    logic signed [BIAS_W-1:0]   bias_reg;
    logic [STD_W-1:0]           std_dev_reg;
    logic [STD_W-1:0]           std_error_reg;
    logic [COUNT_OUT_W-1:0]     count_out_reg;
    logic                       stats_valid_reg;
    logic                       stationary_reg;
    logic                       last_reg;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;
    logic                  sqrt_start;
    logic [2*ROOT_W-1:0]   sqrt_src;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;
    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;

    logic                  in_accept;
    logic                  do_add;
    logic                  zero_mask;
    logic                  cnt_ge2;
    logic                  last_ch;
    logic                  out_load;
    logic signed [MW-1:0]  mean_rd;
    logic [SUM_W-1:0]      sq_rd;
    logic signed [MW-1:0]  x_cur;
    logic signed [DW-1:0]  d_cur;
    logic [DW-1:0]         absd_cur;
    logic signed [DW-1:0]  q_signed;
    logic signed [DW-1:0]  newmean_full;
    logic signed [DW-1:0]  e_cur;
    logic [DW-1:0]         abse_cur;
    logic signed [MW:0]    mean_adj;
    logic [REG_W-1:0]      std_lim;
    logic [127:0]          acc_shift;
    logic [SUM_W-1:0]      p_sat;
    logic [SUM_W:0]        sq_sum;
    logic [SUM_W-1:0]      sq_new;
    logic [PW-1:0]         acc_add;
    logic signed [SAMPLE_BITS-1:0] norm_mean;
    logic [SAMPLE_BITS-1:0]        norm_mag;
    logic [ROOT_W:0]       norm_gap;
    logic signed [33:0]    bias_full;
    logic signed [BIAS_W-1:0] bias_sat;
    logic [ROOT_W-1:0]     std_sel;
    logic [ROOT_W-1:0]     se_sel;
    logic [31:0]           count_wide;

    assign in_accept = (state_reg == ST_IDLE) && in_valid;
    assign do_add = (req_type == REQ_ADD) && (count_reg != '1);
    assign zero_mask = count_reg == '0;
    assign cnt_ge2 = count_reg > COUNT_BITS'(1);
    assign last_ch = ch_reg == CH_ACCEL_Z;
    assign out_load = !out_valid_reg || !out_stall;

    assign mean_rd = zero_mask ? '0 : rd_mean_reg;
    assign sq_rd = zero_mask ? '0 : rd_sq_reg;
    assign x_cur = {samp_reg[ch_reg], {FRAC_BITS{1'b0}}};
    assign d_cur = $signed({x_cur[MW-1], x_cur}) - $signed({mean_rd[MW-1], mean_rd});
    assign absd_cur = d_cur[DW-1] ? DW'(-d_cur) : DW'(d_cur);
    assign q_signed = d_reg[DW-1] ? -$signed(div_quo[DW-1:0]) : $signed(div_quo[DW-1:0]);
    assign newmean_full = $signed({mean_reg[MW-1], mean_reg}) + q_signed;
    assign e_cur = $signed({x_cur[MW-1], x_cur}) - newmean_full;
    assign abse_cur = e_cur[DW-1] ? DW'(-e_cur) : DW'(e_cur);
    assign mean_adj = $signed({mean_rd[MW-1], mean_rd})
                      + (mean_rd[MW-1] ? (MW+1)'((1 << FRAC_BITS) - 1) : '0);
    assign std_lim = (ch_reg < CH_FIRST_ACCEL) ? gyro_lim_reg : accel_lim_reg;

    assign acc_shift = 128'(acc_reg) >> (2 * FRAC_BITS);
    assign p_sat = (|acc_shift[127:SUM_W]) ? '1 : acc_shift[SUM_W-1:0];
    assign sq_sum = {1'b0, sq_reg} + {1'b0, p_sat};
    assign sq_new = sq_sum[SUM_W] ? '1 : sq_sum[SUM_W-1:0];

    always_comb
    begin
        case (step_reg)
            3'd1: acc_add = PW'(prod_reg);
            3'd2: acc_add = PW'(prod_reg) << H;
            3'd3: acc_add = PW'(prod_reg) << H;
            default: acc_add = PW'(prod_reg) << (2 * H);
        endcase
    end

    always_comb
    begin
        case (step_reg)
            3'd1: norm_mean = meanr_reg[4];
            3'd2: norm_mean = meanr_reg[5];
            default: norm_mean = meanr_reg[3];
        endcase
    end

    assign norm_mag = norm_mean[SAMPLE_BITS-1] ? SAMPLE_BITS'(-norm_mean)
                                               : SAMPLE_BITS'(norm_mean);
    assign norm_gap = (sqrt_root > ROOT_W'(gravity_reg))
                      ? (ROOT_W+1)'(sqrt_root - ROOT_W'(gravity_reg))
                      : (ROOT_W+1)'(ROOT_W'(gravity_reg) - sqrt_root);

    assign std_sel = std_reg[ch_reg];
    assign se_sel = se_reg[ch_reg];
    assign bias_full = 34'(meanr_reg[ch_reg])
                       - (last_ch ? $signed({10'd0, gravity_reg}) : 34'sd0);
    always_comb
    begin
        if (zero_mask)
        begin
            bias_sat = '0;
        end
        else if (bias_full > 34'sd8388607)
        begin
            bias_sat = 24'sh7FFFFF;
        end
        else if (bias_full < -34'sd8388608)
        begin
            bias_sat = 24'sh800000;
        end
        else
        begin
            bias_sat = bias_full[BIAS_W-1:0];
        end
    end
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = do_add ? ST_U_RD : ST_R_RD;
                end
            end
            ST_U_RD: state_next = ST_U_DIFF;
            ST_U_DIFF: state_next = ST_U_DIV;
            ST_U_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_U_MUL;
                end
            end
            ST_U_MUL:
            begin
                if (step_reg == 3'd4)
                begin
                    state_next = ST_U_WB;
                end
            end
            ST_U_WB: state_next = last_ch ? ST_R_RD : ST_U_RD;
            ST_R_RD: state_next = ST_R_MEAN;
            ST_R_MEAN: state_next = cnt_ge2 ? ST_R_VAR : ST_R_NEXT;
            ST_R_VAR:
            begin
                if (div_done)
                begin
                    state_next = ST_R_STD;
                end
            end
            ST_R_STD:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_R_SQ;
                end
            end
            ST_R_SQ: state_next = ST_R_SEDIV;
            ST_R_SEDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_R_SESQRT;
                end
            end
            ST_R_SESQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_R_NEXT;
                end
            end
            ST_R_NEXT: state_next = last_ch ? ST_N_MUL : ST_R_RD;
            ST_N_MUL:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = ST_N_START;
                end
            end
            ST_N_START: state_next = (cnt_ge2 && std_ok_reg) ? ST_N_SQRT : ST_EMIT;
            ST_N_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && last_ch)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dividend = DIV_W'(absd_cur);
        div_divisor = count_reg + 1'b1;
        sqrt_start = 1'b0;
        sqrt_src = div_quo;
        mul_a = MUL_W'(a_reg[H-1:0]);
        mul_b = MUL_W'(b_reg[H-1:0]);
        mem_we = 1'b0;
        case (state_reg)
            ST_U_DIFF:
            begin
                div_start = 1'b1;
            end
            ST_U_MUL:
            begin
                case (step_reg)
                    3'd1:
                    begin
                        mul_b = MUL_W'(b_reg[DW-1:H]);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(a_reg[DW-1:H]);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(a_reg[DW-1:H]);
                        mul_b = MUL_W'(b_reg[DW-1:H]);
                    end
                    default:
                    begin
                        mul_a = MUL_W'(a_reg[H-1:0]);
                    end
                endcase
            end
            ST_U_WB:
            begin
                mem_we = 1'b1;
            end
            ST_R_MEAN:
            begin
                div_start = cnt_ge2;
                div_dividend = sq_rd;
                div_divisor = count_reg - 1'b1;
            end
            ST_R_VAR:
            begin
                sqrt_start = div_done;
            end
            ST_R_STD:
            begin
                mul_a = sqrt_root;
                mul_b = sqrt_root;
            end
            ST_R_SQ:
            begin
                div_start = 1'b1;
                div_dividend = prod_reg;
                div_divisor = count_reg;
            end
            ST_R_SEDIV:
            begin
                sqrt_start = div_done;
            end
            ST_N_MUL:
            begin
                mul_a = MUL_W'(norm_mag);
                mul_b = MUL_W'(norm_mag);
            end
            ST_N_START:
            begin
                sqrt_start = cnt_ge2 && std_ok_reg;
                sqrt_src = nsq_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ibwe_div #(
        .VW(COUNT_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_dividend),
        .divisor(div_divisor),
        .done(div_done),
        .quotient(div_quo)
    );

    ibwe_isqrt u_isqrt (
        .clk(clk),
        .rst_n(rst_n),
        .start(sqrt_start),
        .radicand(sqrt_src),
        .done(sqrt_done),
        .root(sqrt_root)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mean_mem[ch_reg] <= newmean_reg;
            sq_mem[ch_reg] <= sq_new;
        end
        rd_mean_reg <= mean_mem[ch_reg];
        rd_sq_reg <= sq_mem[ch_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gravity_reg <= GRAVITY_RESET;
            gyro_lim_reg <= GYRO_STD_LIMIT_RESET;
            accel_lim_reg <= ACCEL_STD_LIMIT_RESET;
            norm_tol_reg <= NORM_TOLERANCE_RESET;
            count_reg <= '0;
            ch_reg <= '0;
            step_reg <= '0;
            std_ok_reg <= 1'b0;
            norm_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GRAVITY: gravity_reg <= cfg_data;
                    REG_GYRO_STD_LIMIT: gyro_lim_reg <= cfg_data;
                    REG_ACCEL_STD_LIMIT: accel_lim_reg <= cfg_data;
                    REG_NORM_TOLERANCE: norm_tol_reg <= cfg_data;
                    default: gravity_reg <= gravity_reg;
                endcase
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    ch_reg <= '0;
                    if (in_valid)
                    begin
                        std_ok_reg <= 1'b1;
                        norm_ok_reg <= 1'b0;
                        if (req_type == REQ_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                    end
                end
                ST_U_DIFF:
                begin
                    step_reg <= '0;
                end
                ST_U_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                ST_U_WB:
                begin
                    if (last_ch)
                    begin
                        ch_reg <= '0;
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_R_STD:
                begin
                    if (sqrt_done && (sqrt_root > ROOT_W'(std_lim)))
                    begin
                        std_ok_reg <= 1'b0;
                    end
                end
                ST_R_NEXT:
                begin
                    step_reg <= '0;
                    ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
                end
                ST_N_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                ST_N_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        norm_ok_reg <= norm_gap <= (ROOT_W+1)'(norm_tol_reg);
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            samp_reg[0] <= gyro_x;
            samp_reg[1] <= gyro_y;
            samp_reg[2] <= gyro_z;
            samp_reg[3] <= accel_x;
            samp_reg[4] <= accel_y;
            samp_reg[5] <= accel_z;
        end
        prod_reg <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
        case (state_reg)
            ST_U_DIFF:
            begin
                mean_reg <= mean_rd;
                sq_reg <= sq_rd;
                d_reg <= d_cur;
                a_reg <= absd_cur;
                acc_reg <= '0;
            end
            ST_U_DIV:
            begin
                if (div_done)
                begin
                    newmean_reg <= newmean_full[MW-1:0];
                    b_reg <= abse_cur;
                end
            end
            ST_U_MUL:
            begin
                if (step_reg != 3'd0)
                begin
                    acc_reg <= acc_reg + acc_add;
                end
            end
            ST_R_MEAN:
            begin
                meanr_reg[ch_reg] <= mean_adj[FRAC_BITS +: SAMPLE_BITS];
                if (!cnt_ge2)
                begin
                    std_reg[ch_reg] <= '0;
                    se_reg[ch_reg] <= '0;
                end
            end
            ST_R_STD:
            begin
                if (sqrt_done)
                begin
                    std_reg[ch_reg] <= sqrt_root;
                end
            end
            ST_R_SESQRT:
            begin
                if (sqrt_done)
                begin
                    se_reg[ch_reg] <= sqrt_root;
                end
            end
            ST_R_NEXT:
            begin
                nsq_reg <= '0;
            end
            ST_N_MUL:
            begin
                if (step_reg != 3'd0)
                begin
                    nsq_reg <= nsq_reg + prod_reg;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    channel_reg <= ch_reg;
                    bias_reg <= bias_sat;
                    std_dev_reg <= (|std_sel[ROOT_W-1:STD_W]) ? '1 : std_sel[STD_W-1:0];
                    std_error_reg <= (|se_sel[ROOT_W-1:STD_W]) ? '1 : se_sel[STD_W-1:0];
                    count_out_reg <= (count_wide > 32'hFFFF) ? '1
                                     : count_wide[COUNT_OUT_W-1:0];
                    stats_valid_reg <= cnt_ge2;
                    stationary_reg <= cnt_ge2 && std_ok_reg && norm_ok_reg;
                    last_reg <= last_ch;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign in_stall = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign channel = channel_reg;
    assign bias = bias_reg;
    assign std_dev = std_dev_reg;
    assign std_error = std_error_reg;
    assign sample_count = count_out_reg;
    assign stats_valid = stats_valid_reg;
    assign stationary = stationary_reg;
    assign last = last_reg;

    a_last_is_accel_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> channel == CH_ACCEL_Z)
        else $error("last result is not on the accel z channel");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stats_valid == (sample_count >= COUNT_OUT_W'(2)))
        else $error("stats_valid disagrees with sample_count");

    a_stationary_needs_stats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stationary |-> stats_valid)
        else $error("stationary reported with fewer than two samples");

    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> in_stall)
        else $error("input open while results are being emitted");

endmodule
`default_nettype wire
